>>> rtl/core/rgcu_pkg.sv
`timescale 1ns / 1ps
// Package for the glyph color usage scanner: word types, command and register
// codes, reset values and the structs passed between the core modules.
// No dependencies.
package rgcu_pkg;

    // Command codes carried in the cmd field of an input word
    localparam logic [1:0] CMD_STREAM = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Register indexes (byte address is 4 * index)
    localparam logic REG_CELL_WIDTH  = 1'b0;
    localparam logic REG_CELL_HEIGHT = 1'b1;

    // Register sizes and reset values
    localparam int CELL_DIM_W      = 10;
    localparam int BUDGET_W        = 2 * CELL_DIM_W;
    localparam logic [CELL_DIM_W-1:0] CELL_DIM_RESET = 10'd8;

    // PackBits code that does nothing
    localparam logic [7:0] CODE_NOOP = 8'h80;

    // Glyph count default and the color map organization
    localparam int GLYPH_COUNT_DEF = 256;
    localparam int NUM_COLORS      = 256;
    localparam int GROUP_SIZE      = 8;
    localparam int NUM_GROUPS      = NUM_COLORS / GROUP_SIZE;

    // Input word
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } item_t;

    // Result word
    typedef struct packed {
        logic [7:0] remap_index;
        logic       color_used;
        logic [8:0] active_colors;
        logic       glyphs_done;
        logic [8:0] glyph_number;
    } result_t;

    // Color mark request from the parser to the color map
    typedef struct packed {
        logic       valid;
        logic [7:0] color;
    } mark_t;

    // Glyph progress from the parser
    typedef struct packed {
        logic       glyphs_done;
        logic [8:0] glyph_number;
    } glyph_status_t;

    // Color map lookup for the word registered at acceptance
    typedef struct packed {
        logic       valid;
        logic [7:0] remap_index;
        logic       color_used;
        logic [8:0] active_colors;
    } lookup_t;

endpackage

>>> rtl/core/rgcu_cfg.sv
`timescale 1ns / 1ps
// APB register file: cell width and height, plus the registered pixel budget
// (width * height) used at each glyph start. Depends on rgcu_pkg.
module rgcu_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output logic [rgcu_pkg::BUDGET_W-1:0]        budget
);
    import rgcu_pkg::*;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(CELL_DIM_RESET * CELL_DIM_RESET);

    logic [CELL_DIM_W-1:0] width_reg;
    logic [CELL_DIM_W-1:0] height_reg;
    logic [BUDGET_W-1:0]   budget_reg;
    logic [BUDGET_W-1:0]   budget_next;
    logic                  wr_en;
    logic                  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CELL_DIM_RESET;
            height_reg <= CELL_DIM_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_CELL_WIDTH)
                width_reg <= pwdata[CELL_DIM_W-1:0];
            else
                height_reg <= pwdata[CELL_DIM_W-1:0];
        end
    end

    // Read mux
    always_comb
    begin
        if (reg_sel == REG_CELL_WIDTH)
            prdata = {{(32-CELL_DIM_W){1'b0}}, width_reg};
        else
            prdata = {{(32-CELL_DIM_W){1'b0}}, height_reg};
    end

    // Budget product from the written value, updated at the same edge as the sizes
    always_comb
    begin
        budget_next = budget_reg;
        if (wr_en)
        begin
            if (reg_sel == REG_CELL_WIDTH)
                budget_next = BUDGET_W'(pwdata[CELL_DIM_W-1:0]) * BUDGET_W'(height_reg);
            else
                budget_next = BUDGET_W'(width_reg) * BUDGET_W'(pwdata[CELL_DIM_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            budget_reg <= BUDGET_RESET;
        else
            budget_reg <= budget_next;
    end

    assign budget = budget_reg;

endmodule

>>> rtl/core/rgcu_parse.sv
`timescale 1ns / 1ps
// PackBits stream parser: tracks the glyph budget, run phase and glyph count,
// and asks the color map to mark each color byte. Depends on rgcu_pkg.
module rgcu_parse #(
    parameter int GLYPH_COUNT = rgcu_pkg::GLYPH_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  rgcu_pkg::item_t                item,
    input  logic [rgcu_pkg::BUDGET_W-1:0]  budget,
    output rgcu_pkg::mark_t                mark,
    output rgcu_pkg::glyph_status_t        status
);
    import rgcu_pkg::*;

    localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_COUNT);

    // Parse phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_CODE  = 2'd1;
    localparam logic [1:0] PH_LIT   = 2'd2;
    localparam logic [1:0] PH_REP   = 2'd3;

    logic [1:0]          phase_reg,   phase_next;
    logic [BUDGET_W-1:0] pixels_reg,  pixels_next;
    logic [7:0]          lit_reg,     lit_next;
    logic [8:0]          glyph_reg,   glyph_next;

    logic                all_done;
    logic                stream_en;
    logic                clear_en;
    logic [7:0]          b;
    logic [BUDGET_W-1:0] base;
    logic [7:0]          run_len;
    logic [BUDGET_W-1:0] spent;
    logic [7:0]          lit_dec;

    assign all_done  = (glyph_reg >= GLYPH_LIMIT);
    assign stream_en = accept && (item.cmd == CMD_STREAM) && !all_done;
    assign clear_en  = accept && (item.cmd == CMD_CLEAR);
    assign b         = item.data_byte;

    // Budget at hand: reloaded at a glyph start
    assign base    = (phase_reg == PH_START) ? budget : pixels_reg;
    // Pixels taken by a code: b+1 for literals, 257-b for a repeat
    assign run_len = b[7] ? 8'(9'd257 - {1'b0, b}) : 8'({1'b0, b[6:0]} + 8'd1);
    assign spent   = (base > {{(BUDGET_W-8){1'b0}}, run_len})
                   ? (base - {{(BUDGET_W-8){1'b0}}, run_len}) : '0;
    assign lit_dec = lit_reg - 8'd1;

    // Next-state logic
    always_comb
    begin
        phase_next  = phase_reg;
        pixels_next = pixels_reg;
        lit_next    = lit_reg;
        glyph_next  = glyph_reg;
        mark.valid  = 1'b0;
        mark.color  = b;
        if (clear_en)
        begin
            phase_next  = PH_START;
            pixels_next = '0;
            lit_next    = '0;
            glyph_next  = '0;
        end
        else if (stream_en)
        begin
            case (phase_reg)
                PH_START, PH_CODE:
                begin
                    if (!b[7])
                    begin
                        pixels_next = spent;
                        lit_next    = run_len;
                        phase_next  = PH_LIT;
                    end
                    else if (b == CODE_NOOP)
                    begin
                        // no-op code still ends the glyph once the budget is gone
                        pixels_next = base;
                        if (base == '0)
                        begin
                            glyph_next = glyph_reg + 9'd1;
                            phase_next = PH_START;
                        end
                        else
                            phase_next = PH_CODE;
                    end
                    else
                    begin
                        pixels_next = spent;
                        phase_next  = PH_REP;
                    end
                end
                PH_LIT:
                begin
                    mark.valid = 1'b1;
                    lit_next   = lit_dec;
                    if (lit_dec == 8'd0)
                    begin
                        if (pixels_reg == '0)
                        begin
                            glyph_next = glyph_reg + 9'd1;
                            phase_next = PH_START;
                        end
                        else
                            phase_next = PH_CODE;
                    end
                end
                default:
                begin
                    // repeat byte
                    mark.valid = 1'b1;
                    if (pixels_reg == '0)
                    begin
                        glyph_next = glyph_reg + 9'd1;
                        phase_next = PH_START;
                    end
                    else
                        phase_next = PH_CODE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            pixels_reg <= '0;
            lit_reg    <= '0;
            glyph_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pixels_reg <= pixels_next;
            lit_reg    <= lit_next;
            glyph_reg  <= glyph_next;
        end
    end

    assign status.glyphs_done  = all_done;
    assign status.glyph_number = glyph_reg;

endmodule

>>> rtl/core/rgcu_cmap.sv
`timescale 1ns / 1ps
// Color used map with per-group running counts, so a remap index is one
// group count plus a popcount inside an 8-color group. Depends on rgcu_pkg.
module rgcu_cmap (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  rgcu_pkg::item_t      item,
    input  rgcu_pkg::mark_t      mark,
    output rgcu_pkg::lookup_t    lookup
);
    import rgcu_pkg::*;

    logic [NUM_COLORS-1:0] map_reg;
    // cum_reg[g]: used colors 1..255 that lie in groups below g
    logic [7:0]            cum_reg [NUM_GROUPS];
    logic [7:0]            count_reg;
    logic                  q_valid_reg;
    item_t                 q_item_reg;

    logic                  clear_en;
    logic                  new_color;
    logic [4:0]            mark_grp;
    logic [4:0]            q_grp;
    logic [GROUP_SIZE-1:0] q_bits;
    logic [3:0]            q_pc;
    logic [7:0]            prefix;
    logic                  q_used;
    logic                  is_query;

    assign clear_en  = accept && (item.cmd == CMD_CLEAR);
    assign new_color = mark.valid && (mark.color != 8'd0) && !map_reg[mark.color];
    assign mark_grp  = mark.color[7:3];

    // Map bits and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '0;
            count_reg <= '0;
        end
        else if (clear_en)
        begin
            map_reg   <= '0;
            count_reg <= '0;
        end
        else if (mark.valid)
        begin
            map_reg[mark.color] <= 1'b1;
            if (new_color)
                count_reg <= count_reg + 8'd1;
        end
    end

    // Group prefix counts: every group above a new color moves up by one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
                cum_reg[g] <= '0;
        end
        else if (clear_en)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
                cum_reg[g] <= '0;
        end
        else if (new_color)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
                if (5'(g) > mark_grp)
                    cum_reg[g] <= cum_reg[g] + 8'd1;
        end
    end

    // Word held for the lookup against the updated map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else
            q_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_item_reg <= item;
    end

    // Lookup: group prefix plus used colors up to the queried one in its group
    assign q_grp  = q_item_reg.data_byte[7:3];
    assign q_bits = map_reg[{q_grp, 3'b000} +: GROUP_SIZE];

    always_comb
    begin
        q_pc = '0;
        for (int j = 0; j < GROUP_SIZE; j++)
        begin
            if (q_bits[j] && (3'(j) <= q_item_reg.data_byte[2:0])
                && !((q_grp == 5'd0) && (j == 0)))
                q_pc = q_pc + 4'd1;
        end
    end

    assign prefix   = cum_reg[q_grp] + {4'b0000, q_pc};
    assign q_used   = map_reg[q_item_reg.data_byte];
    assign is_query = (q_item_reg.cmd == CMD_QUERY);

    assign lookup.valid         = q_valid_reg;
    assign lookup.remap_index   = (is_query && q_used) ? prefix : 8'd0;
    assign lookup.color_used    = is_query && q_used;
    assign lookup.active_colors = {1'b0, count_reg} + 9'd1;

endmodule

>>> rtl/core/rle_glyph_color_usage_scan.sv
`timescale 1ns / 1ps
// Glyph color usage scanner: parses a PackBits glyph stream one byte per word
// and answers color remap queries. Depends on rgcu_pkg and the rgcu modules.
//
// One word is accepted every clock cycle; busy is never raised. Each accepted
// word gives exactly one result, shown on result with done high for one cycle,
// after the word has passed the color map's lookup register, which sees the
// updated map, then the result register. The remap lookup is one 8-bit group
// prefix count plus a popcount of eight map bits, so nothing limits the rate
// below one word per cycle. A clear command empties the map in the cycle it
// is accepted; there is no clearing pass after reset. The receiver must take
// each result in its cycle. Size changes through the APB port take effect at
// the next glyph start, including a glyph that starts right after the write.
module rle_glyph_color_usage_scan #(
    parameter int GLYPH_COUNT = rgcu_pkg::GLYPH_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rgcu_pkg::item_t      item,
    output logic                 done,
    output rgcu_pkg::result_t    result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import rgcu_pkg::*;

    logic                accept;
    logic [BUDGET_W-1:0] budget;
    mark_t               mark;
    glyph_status_t       status;
    lookup_t             lookup;
    logic                done_reg;
    result_t             result_reg;
    result_t             result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers
    rgcu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .budget  (budget)
    );

    // Stream parser
    rgcu_parse #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .budget (budget),
        .mark   (mark),
        .status (status)
    );

    // Color map and remap lookup
    rgcu_cmap u_cmap (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .mark   (mark),
        .lookup (lookup)
    );

    // Result word: lookup plus glyph progress, both after the word's update
    always_comb
    begin
        result_next.remap_index   = lookup.remap_index;
        result_next.color_used    = lookup.color_used;
        result_next.active_colors = lookup.active_colors;
        result_next.glyphs_done   = status.glyphs_done;
        result_next.glyph_number  = status.glyph_number;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= lookup.valid;
    end

    always_ff @(posedge clk)
    begin
        if (lookup.valid)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/core/rgcu_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the glyph color usage scanner, bound to the top
// level. Depends on rgcu_pkg.
module rgcu_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 done,
    input  rgcu_pkg::result_t    result
);
    import rgcu_pkg::*;

    // Every accepted word gives a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after an accepted word");

    // No result without an accepted word
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without an accepted word");

    // A nonzero remap index belongs to a used color
    a_remap_used: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.remap_index != 8'd0)) |-> result.color_used)
        else $error("remap index given for an unused color");

    // Remap index never exceeds the number of used colors
    a_remap_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, result.remap_index} < result.active_colors))
        else $error("remap index beyond active color count");

    // A result with glyphs_done set implies at least one glyph completed
    a_glyph_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.glyphs_done) |-> (result.glyph_number != 9'd0))
        else $error("glyphs done with no glyph counted");

endmodule

bind rle_glyph_color_usage_scan rgcu_checker u_rgcu_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

>>> bench/rle_glyph_color_usage_scan_tb.sv
`timescale 1ns / 1ps
// Testbench for the glyph color usage scanner: sends stream, query and clear words,
// tracks the used-color map and the parse state alongside, and checks every result.
// Depends on rgcu_pkg and rle_glyph_color_usage_scan.
module rle_glyph_color_usage_scan_tb;
    import rgcu_pkg::*;

    localparam int NGLYPH = GLYPH_COUNT_DEF;
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int MAX_PRINTED = 40;

    // Parser position within a glyph
    typedef enum logic [1:0] {GLYPH_OPEN, CODE_WAIT, LIT_RUN, REP_BYTE} parse_phase_e;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  done;
    result_t               result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Shadow of the scanner state
    logic [NUM_COLORS-1:0] color_seen;
    logic [21:0]           budget_left;
    parse_phase_e          phase;
    logic [7:0]            literals_due;
    logic [8:0]            glyphs_parsed;
    logic [CELL_DIM_W-1:0] width_q;
    logic [CELL_DIM_W-1:0] height_q;

    result_t               pending_results[$];
    int                    words_counted = 0;
    int                    error_count = 0;
    int                    sender_idle_pct = 0;

    rle_glyph_color_usage_scan #(
        .GLYPH_COUNT(NGLYPH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Clear command and reset: map and parse state only, registers untouched
    task automatic clear_model();
        color_seen = '0;
        budget_left = '0;
        phase = GLYPH_OPEN;
        literals_due = '0;
        glyphs_parsed = '0;
    endtask

    task automatic spend_pixels(input int n);
        budget_left = (budget_left > n) ? budget_left - 22'(n) : '0;
    endtask

    // A code and its data are done: the glyph ends once the budget is used up
    task automatic close_code();
        if (budget_left == '0)
        begin
            glyphs_parsed = glyphs_parsed + 9'd1;
            phase = GLYPH_OPEN;
        end
        else
            phase = CODE_WAIT;
    endtask

    // Apply one accepted word to the shadow state and queue its expected result
    task automatic predict_scan_result(input logic [1:0] op, input logic [7:0] b);
        result_t want;
        int      tally;
        int      remap;
        want = '0;
        if (op == CMD_STREAM && glyphs_parsed < NGLYPH)
        begin
            words_counted++;
            case (phase)
                GLYPH_OPEN, CODE_WAIT:
                begin
                    if (phase == GLYPH_OPEN)
                        budget_left = {12'd0, width_q} * {12'd0, height_q};
                    if (b < 8'd128)
                    begin
                        spend_pixels(int'(b) + 1);
                        literals_due = b + 8'd1;
                        phase = LIT_RUN;
                    end
                    else if (b == CODE_NOOP)
                        close_code();
                    else
                    begin
                        spend_pixels(257 - int'(b));
                        phase = REP_BYTE;
                    end
                end
                LIT_RUN:
                begin
                    color_seen[b] = 1'b1;
                    literals_due = literals_due - 8'd1;
                    if (literals_due == '0)
                        close_code();
                end
                default:
                begin
                    color_seen[b] = 1'b1;
                    close_code();
                end
            endcase
        end
        else if (op == CMD_CLEAR)
        begin
            words_counted++;
            clear_model();
        end
        else if (op == CMD_QUERY)
            words_counted++;

        // Dense numbering of used colors 1..255
        tally = 0;
        remap = 0;
        for (int i = 1; i < NUM_COLORS; i++)
        begin
            if (color_seen[i])
            begin
                tally++;
                if (i == b)
                    remap = tally;
            end
        end
        if (op == CMD_QUERY)
        begin
            want.remap_index = remap[7:0];
            want.color_used = color_seen[b];
        end
        want.active_colors = 9'(tally + 1);
        want.glyphs_done = (glyphs_parsed >= NGLYPH);
        want.glyph_number = glyphs_parsed;
        pending_results.push_back(want);
    endtask

    // Result checker: one word per done strobe, in order
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", int'(result), 0);
            else
            begin
                want = pending_results.pop_front();
                if (result.remap_index !== want.remap_index)
                    report_mismatch("remap_index", result.remap_index, want.remap_index);
                if (result.color_used !== want.color_used)
                    report_mismatch("color_used", result.color_used, want.color_used);
                if (result.active_colors !== want.active_colors)
                    report_mismatch("active_colors", result.active_colors,
                                    want.active_colors);
                if (result.glyphs_done !== want.glyphs_done)
                    report_mismatch("glyphs_done", result.glyphs_done, want.glyphs_done);
                if (result.glyph_number !== want.glyph_number)
                    report_mismatch("glyph_number", result.glyph_number, want.glyph_number);
            end
        end
    end

    // Send one word; start stays high unless an idle gap follows
    task automatic send_word(input logic [1:0] op, input logic [7:0] b);
        start <= 1'b1;
        item <= item_t'{op, b};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_scan_result(op, b);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write, upper data bits random; the scanner must be idle
    task automatic write_reg(input logic idx, input logic [CELL_DIM_W-1:0] value);
        logic [31:0] wd;
        wd = $urandom;
        wd[CELL_DIM_W-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= wd;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_CELL_WIDTH)
            width_q = value;
        else
            height_q = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    task automatic read_reg(input logic idx);
        logic [CELL_DIM_W-1:0] want;
        want = (idx == REG_CELL_WIDTH) ? width_q : height_q;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CELL_DIM_W-1:0] !== want)
            report_mismatch("register read", prdata[CELL_DIM_W-1:0], want);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Colors lean toward both ends of the palette so queries hit used entries
    function automatic logic [7:0] pick_color();
        case ($urandom_range(3))
            1: return 8'($urandom_range(7));
            2: return 8'($urandom_range(255, 248));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One well-formed code with its data, queries sometimes mixed into literals
    task automatic send_code_run();
        int kind;
        int n;
        kind = $urandom_range(9);
        if (kind < 4)
        begin
            n = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(3);
            send_word(CMD_STREAM, 8'(n));
            for (int k = 0; k <= n; k++)
            begin
                if ($urandom_range(19) == 0)
                    send_word(CMD_QUERY, pick_color());
                send_word(CMD_STREAM, pick_color());
            end
        end
        else if (kind < 8)
        begin
            send_word(CMD_STREAM, 8'($urandom_range(255, 129)));
            send_word(CMD_STREAM, pick_color());
        end
        else
            send_word(CMD_STREAM, CODE_NOOP);
    endtask

    // One random phase at a given cell size; clears at random and now and then once done
    task automatic run_traffic(input logic [CELL_DIM_W-1:0] w, input logic [CELL_DIM_W-1:0] h,
                               input int words, input int idle_pct, input int clear_permille);
        int goal;
        int pick;
        write_reg(REG_CELL_WIDTH, w);
        write_reg(REG_CELL_HEIGHT, h);
        sender_idle_pct = idle_pct;
        goal = words_counted + words;
        while (words_counted < goal)
        begin
            pick = $urandom_range(99);
            if ((glyphs_parsed >= NGLYPH && $urandom_range(7) == 0)
                || $urandom_range(999) < clear_permille)
                send_word(CMD_CLEAR, 8'($urandom));
            else if (pick < 62)
                send_code_run();
            else if (pick < 80)
                send_word(CMD_QUERY, pick_color());
            else if (pick < 94)
                send_word(CMD_STREAM, 8'($urandom));
            else
                send_word(CMD_RESERVED, 8'($urandom));
        end
        wait_drained();
    endtask

    // Literal, repeat and no-op codes, overrun, reserved command, queries, clear
    task automatic test_code_types();
        sender_idle_pct = 0;
        send_word(CMD_QUERY, 8'h00);
        send_word(CMD_STREAM, 8'h02);
        send_word(CMD_STREAM, 8'h00);
        send_word(CMD_STREAM, 8'hFF);
        send_word(CMD_STREAM, 8'h05);
        send_word(CMD_STREAM, CODE_NOOP);
        // repeat of 128 overruns the 64-pixel budget and closes the glyph
        send_word(CMD_STREAM, 8'h81);
        send_word(CMD_STREAM, 8'h7F);
        send_word(CMD_RESERVED, 8'hAA);
        send_word(CMD_QUERY, 8'h00);
        send_word(CMD_QUERY, 8'h05);
        send_word(CMD_QUERY, 8'h7F);
        send_word(CMD_QUERY, 8'hFF);
        send_word(CMD_QUERY, 8'h10);
        send_word(CMD_STREAM, 8'hFF);
        send_word(CMD_STREAM, 8'h80);
        send_word(CMD_QUERY, 8'h80);
        send_word(CMD_CLEAR, 8'h55);
        send_word(CMD_QUERY, 8'hFF);
        wait_drained();
    endtask

    // Reset values, then both extremes written and read back
    task automatic test_register_access();
        read_reg(REG_CELL_WIDTH);
        read_reg(REG_CELL_HEIGHT);
        write_reg(REG_CELL_WIDTH, 10'd1023);
        read_reg(REG_CELL_WIDTH);
        write_reg(REG_CELL_HEIGHT, 10'd0);
        read_reg(REG_CELL_HEIGHT);
        write_reg(REG_CELL_HEIGHT, 10'd1023);
        read_reg(REG_CELL_HEIGHT);
    endtask

    // Zero-size cells: each glyph is a single code plus its data
    task automatic test_empty_cell();
        write_reg(REG_CELL_WIDTH, 10'd0);
        sender_idle_pct = 62;
        send_word(CMD_STREAM, CODE_NOOP);
        send_word(CMD_STREAM, 8'h00);
        send_word(CMD_STREAM, 8'h42);
        send_word(CMD_STREAM, 8'hC0);
        send_word(CMD_STREAM, 8'h01);
        send_word(CMD_QUERY, 8'h42);
        wait_drained();
        write_reg(REG_CELL_WIDTH, 10'd1023);
        write_reg(REG_CELL_HEIGHT, 10'd0);
        send_word(CMD_STREAM, 8'h01);
        send_word(CMD_STREAM, 8'h03);
        send_word(CMD_STREAM, 8'h04);
        send_word(CMD_QUERY, 8'h04);
        wait_drained();
    endtask

    // Long random streams; the first two phases send no random clears so the
    // glyph count reaches its limit and trailing bytes get ignored
    task automatic test_random_streams();
        run_traffic(10'd1, 10'd1, 700, 0, 0);
        run_traffic(10'd0, 10'd1023, 700, 62, 0);
        run_traffic(10'd3, 10'd5, 350, 8, 3);
        run_traffic(10'd1023, 10'd1023, 80, 0, 0);
        run_traffic(10'd8, 10'd8, 200, 62, 10);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        width_q = CELL_DIM_RESET;
        height_q = CELL_DIM_RESET;
        clear_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_code_types();
        test_register_access();
        test_empty_cell();
        test_random_streams();

        if (error_count == 0)
            $display("rle_glyph_color_usage_scan_tb OK");
        else
            $display("rle_glyph_color_usage_scan_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("rle_glyph_color_usage_scan_tb NOT OK");
        $finish;
    end

endmodule
